[hw/rtl/g711c_pkg.sv]
// Package for the G.711 A-law / mu-law codec.
// Holds the law and operation codes, the decoder, and the encoder threshold tables.
// Stands alone; used by g711_alaw_ulaw_codec.
package g711c_pkg;

	localparam logic LAW_MU = 1'b0;
	localparam logic LAW_A  = 1'b1;

	localparam logic FUNC_ENCODE = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	localparam logic [7:0]  MU_MASK    = 8'hff;
	localparam logic [7:0]  A_MASK     = 8'hd5;
	localparam logic [7:0]  A_TOGGLE   = 8'h55;
	localparam logic [7:0]  MU_BIAS    = 8'h84;
	localparam logic [13:0] IDX_CENTRE = 14'd8192;

	localparam int NUM_CUTS = 127;
	localparam int CUT_W    = 13;

	// Encoder thresholds.
	// Entry i is the cut between positive levels i and i+1, on the 13-bit magnitude scale.
	typedef logic [NUM_CUTS-1:0][CUT_W-1:0] cut_tab_t;

	// Positive decoded level for code position i (0..127) under a law.
	function automatic int level(input logic law, input int i);
		int q;
		int s;
		q = i & 15;
		s = i >> 4;
		if (law == LAW_A) begin
			level = (s != 0) ? ((2 * q + 33) << (s + 2)) : ((2 * q + 1) << 3);
		end else begin
			level = (((q << 3) + 132) << s) - 132;
		end
	endfunction

	function automatic cut_tab_t build_cuts(input logic law);
		cut_tab_t tab;
		int       c;
		for (int i = 0; i < NUM_CUTS; i++) begin
			c = (level(law, i) + level(law, i + 1) + 4) >>> 3;
			tab[i] = c[CUT_W-1:0];
		end
		return tab;
	endfunction

	localparam cut_tab_t CUT_MU = build_cuts(LAW_MU);
	localparam cut_tab_t CUT_A  = build_cuts(LAW_A);

	// Expands one code byte to a linear sample.
	function automatic logic signed [15:0] expand(input logic law, input logic [7:0] code);
		logic [7:0]  u;
		logic [15:0] t;
		logic [15:0] mag;
		if (law == LAW_A) begin
			u = code ^ A_TOGGLE;
			if (u[6:4] != 3'd0) begin
				t = 16'({u[3:0], 1'b1} + 6'd32) << ({1'b0, u[6:4]} + 4'd2);
			end else begin
				t = 16'({u[3:0], 1'b1}) << 3;
			end
			expand = u[7] ? t : (16'd0 - t);
		end else begin
			u   = ~code;
			t   = 16'({u[3:0], 3'b000} + MU_BIAS) << u[6:4];
			mag = t - 16'(MU_BIAS);
			expand = u[7] ? (16'd0 - mag) : mag;
		end
	endfunction

endpackage

[hw/rtl/g711_alaw_ulaw_codec.sv]
// Top level of the G.711 A-law / mu-law codec: a three-stage pipeline.
// Depends on g711c_pkg for codes, the decoder function and the threshold tables.
//
//  Channel  | Direction | Signals                               | Word
//  ---------+-----------+---------------------------------------+----------------------------------
//  s_axis   | in        | tvalid, tready, tdata[23:0], tuser    | sample/code in, tuser = operation
//  m_axis   | out       | tvalid, tready, tdata[23:0]           | code and linear sample out
//  cfg      | in        | valid, ready, data                    | companding law
//
// The block takes one word per cycle while the output side does not stall; each word passes
// through the three pipeline registers (offset/magnitude, segment search, step search within
// the segment).
// Reset clears the valid bits and selects mu-law. All stages advance together whenever the
// last stage is empty or its word is taken, so a stall freezes the pipeline in place and
// an input word is taken in the same cycle that the output word leaves.
module g711_alaw_ulaw_codec (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [15:0] pcm_sample, [23:16] code_byte
	input  logic        s_axis_tuser,   // [0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] code_out, [23:8] pcm_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	localparam int CW = g711c_pkg::CUT_W;

	logic law_q;

	// Stage registers.
	logic           v_s1, v_s2, v_s3;
	logic           func_s1, func_s2, func_s3;
	logic           law_s1, law_s2;
	logic           neg_s1, neg_s2, neg_s3;
	logic [CW-1:0]  j_s1, j_s2;
	logic [7:0]     code_s1;
	logic [2:0]     seg_s2;
	logic [15:0]    pcm_s2, pcm_s3;
	logic [7:0]     code_s3;

	logic           adv;
	logic [13:0]    idx;
	logic [13:0]    idx_fix;
	logic [13:0]    below;
	logic [CW-1:0]  j_in;
	logic           neg_in;
	logic [6:0]     seg_hits;
	logic [2:0]     seg_in;
	logic [14:0]    step_hits;
	logic [3:0]     step_in;
	logic [7:0]     mask_s2;
	logic [7:0]     code_in;
	g711c_pkg::cut_tab_t cuts_s1, cuts_s2;

	// The whole pipeline moves as one when the output register can be refilled.
	assign adv           = !v_s3 || m_axis_tready;
	assign s_axis_tready = adv;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = {pcm_s3, code_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			law_q <= g711c_pkg::LAW_MU;
		end else if (cfg_valid && cfg_ready) begin
			law_q <= cfg_data;
		end
	end

	// Stage 1: offset-binary index with the two low bits dropped, folded to a magnitude
	// around the centre. The lowest index takes the code of its neighbor.
	always_comb begin
		idx     = {~s_axis_tdata[15], s_axis_tdata[14:2]};
		idx_fix = (idx == 14'd0) ? 14'd1 : idx;
		below   = g711c_pkg::IDX_CENTRE - idx_fix;
		neg_in  = !idx_fix[13];
		j_in    = idx_fix[13] ? idx_fix[CW-1:0] : below[CW-1:0];
	end

	// Stage 2: pick the segment by comparing against the cut at the top of each segment.
	always_comb begin
		cuts_s1 = (law_s1 == g711c_pkg::LAW_A) ? g711c_pkg::CUT_A : g711c_pkg::CUT_MU;
		for (int k = 0; k < 7; k++) begin
			seg_hits[k] = cuts_s1[k * 16 + 15] <= j_s1;
		end
		seg_in = 3'($countones(seg_hits));
	end

	// Stage 3: count the cuts inside the chosen segment that the magnitude has passed.
	always_comb begin
		cuts_s2 = (law_s2 == g711c_pkg::LAW_A) ? g711c_pkg::CUT_A : g711c_pkg::CUT_MU;
		for (int m = 0; m < 15; m++) begin
			step_hits[m] = cuts_s2[{seg_s2, 4'(m)}] <= j_s2;
		end
		step_in = 4'($countones(step_hits));
		mask_s2 = (law_s2 == g711c_pkg::LAW_A) ? g711c_pkg::A_MASK : g711c_pkg::MU_MASK;
		code_in = {1'b0, seg_s2, step_in} ^ mask_s2 ^ {neg_s2, 7'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= s_axis_tuser;
			law_s1  <= law_q;
			neg_s1  <= neg_in;
			j_s1    <= j_in;
			code_s1 <= s_axis_tdata[23:16];

			func_s2 <= func_s1;
			law_s2  <= law_s1;
			neg_s2  <= neg_s1;
			j_s2    <= j_s1;
			seg_s2  <= seg_in;
			pcm_s2  <= g711c_pkg::expand(law_s1, code_s1);

			func_s3 <= func_s2;
			neg_s3  <= neg_s2;
			code_s3 <= (func_s2 == g711c_pkg::FUNC_ENCODE) ? code_in : 8'd0;
			pcm_s3  <= (func_s2 == g711c_pkg::FUNC_DECODE) ? pcm_s2 : 16'd0;
		end
	end

	// A word accepted into a free-running pipeline reaches the output after three stages.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 adv ##1 adv |=> m_axis_tvalid)
		else $error("accepted word did not reach the output in three stages");

	// Both laws keep the sign in the top code bit, inverted relative to the magnitude side.
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && func_s3 == g711c_pkg::FUNC_ENCODE) |-> (code_s3[7] == !neg_s3))
		else $error("encoded sign bit disagrees with sample sign");

	a_dec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && func_s3 == g711c_pkg::FUNC_DECODE) |-> (code_s3 == 8'd0))
		else $error("code field not cleared on a decode word");

	a_enc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && func_s3 == g711c_pkg::FUNC_ENCODE) |-> (pcm_s3 == 16'd0))
		else $error("sample field not cleared on an encode word");

endmodule

[verif/tb_g711_alaw_ulaw_codec.sv]
// Self-checking testbench for the G.711 A-law / mu-law codec, g711_alaw_ulaw_codec.
// An independent model predicts each result word, with random idling on both streams.
// Depends on g711c_pkg for the law, operation and mask constants.
`timescale 1ns / 1ps

// One result word as it leaves the block: the code from an encode and the linear sample
// from a decode. The field not produced by the operation is zero.
typedef struct packed {
	logic [15:0] pcm;
	logic [7:0]  code;
} codec_result_t;

// Scoreboard: predicts the result of every accepted input word under the current law and
// compares the words leaving the block against those predictions in order.
class codec_scoreboard;
	logic          law;
	codec_result_t expected_words[$];
	int            mismatches;

	function new();
		law        = g711c_pkg::LAW_MU;
		mismatches = 0;
	endfunction

	// Linear level of one code byte under a law, as a signed integer.
	function int expand_code(logic l, logic [7:0] c);
		logic [7:0] a;
		int         q;
		int         seg;
		int         t;
		int         bias;
		if (l == g711c_pkg::LAW_A) begin
			a   = c ^ g711c_pkg::A_TOGGLE;
			q   = a[3:0];
			seg = a[6:4];
			if (seg != 0) begin
				t = (2 * q + 33) << (seg + 2);
			end else begin
				t = (2 * q + 1) << 3;
			end
			return a[7] ? t : -t;
		end else begin
			a    = ~c;
			q    = a[3:0];
			seg  = a[6:4];
			bias = g711c_pkg::MU_BIAS;
			t    = ((q << 3) + bias) << seg;
			return a[7] ? (bias - t) : (t - bias);
		end
	endfunction

	// Nearest code for a 14-bit offset index: walk the positive levels until the index
	// falls below the midpoint to the next one, then fold in the sign.
	function logic [7:0] compress_index(logic l, logic [13:0] idx);
		logic [7:0] mask;
		logic [7:0] neg;
		logic [7:0] pos;
		int         j;
		int         cut;
		mask = (l == g711c_pkg::LAW_A) ? g711c_pkg::A_MASK : g711c_pkg::MU_MASK;
		neg  = 8'h00;
		pos  = 8'd127;
		// The very bottom index has no level of its own and borrows its neighbor's code.
		if (idx == 14'd0) begin
			idx = 14'd1;
		end
		if (idx >= g711c_pkg::IDX_CENTRE) begin
			j = idx - g711c_pkg::IDX_CENTRE;
		end else begin
			j   = g711c_pkg::IDX_CENTRE - idx;
			neg = 8'h80;
		end
		for (int i = 0; i < 127; i++) begin
			cut = (expand_code(l, 8'(i) ^ mask) + expand_code(l, 8'(i + 1) ^ mask) + 4) >>> 3;
			if (j < cut) begin
				pos = 8'(i);
				break;
			end
		end
		return pos ^ mask ^ neg;
	endfunction

	function void note_input(logic func, logic [15:0] pcm, logic [7:0] code);
		codec_result_t r;
		int            lin;
		if (func == g711c_pkg::FUNC_ENCODE) begin
			// Offset binary: flip the sign bit, then drop the two low bits.
			r.code = compress_index(law, {~pcm[15], pcm[14:2]});
			r.pcm  = 16'd0;
		end else begin
			lin    = expand_code(law, code);
			r.code = 8'd0;
			r.pcm  = lin[15:0];
		end
		expected_words.push_back(r);
	endfunction

	function void check_result(logic [23:0] word);
		codec_result_t exp_word;
		codec_result_t act_word;
		act_word = word;
		if (expected_words.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("unexpected output word %h at %0t", word, $realtime);
			end
			return;
		end
		exp_word = expected_words.pop_front();
		if (act_word.code !== exp_word.code || act_word.pcm !== exp_word.pcm) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch at %0t: code_out exp %h got %h, pcm_out exp %h got %h",
					$realtime, exp_word.code, act_word.code, exp_word.pcm, act_word.pcm);
			end
		end
	endfunction
endclass

module tb_g711_alaw_ulaw_codec;

	// Three pipeline registers inside the block; the drain wait covers any slack.
	localparam int PIPE_DEPTH     = 3;
	localparam int DRAIN_CYCLES   = 8;
	// Longest legal quiet stretch is a sender gap plus a receiver stall plus the pipeline;
	// the limit leaves a wide margin on top of that.
	localparam int WATCHDOG_LIMIT = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // [15:0] pcm_sample, [23:16] code_byte
	logic        s_axis_tuser = 1'b0; // [0] func
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // [7:0] code_out, [23:8] pcm_out
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;

	codec_scoreboard sb;

	// Idle rates in percent for the sending and receiving sides. They are re-drawn in
	// stretches so that some parts of the run see heavy idling and some none at all.
	// In the closing part of the run both sides stay busy.
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	bit quiet         = 1'b0;

	g711_alaw_ulaw_codec dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// Picks an idle rate: none, light or heavy.
	function automatic int pick_idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	// Presents one input word, with an optional idle burst in front of it, and returns at
	// the edge where it is accepted. The prediction is made at that same edge, so it always
	// uses the law in force when the block took the word.
	task automatic drive_word(input logic func, input logic [15:0] pcm, input logic [7:0] code);
		if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= {code, pcm};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		sb.note_input(func, pcm, code);
	endtask

	// Changes the law. The block must be empty first: wait for every predicted word to come
	// out, let the pipeline settle, then do the register write.
	task automatic set_law(input logic l);
		s_axis_tvalid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 1) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= l;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		sb.law = l;
	endtask

	// Extremes of both operations. The two lowest samples share index zero, which borrows
	// the code of the next index; the unused field of most words is filled at random so that
	// the block is seen to ignore it.
	task automatic run_directed();
		drive_word(g711c_pkg::FUNC_ENCODE, 16'h8000, 8'($urandom));
		drive_word(g711c_pkg::FUNC_ENCODE, 16'h8003, 8'($urandom));
		drive_word(g711c_pkg::FUNC_ENCODE, 16'h8004, 8'($urandom));
		drive_word(g711c_pkg::FUNC_ENCODE, 16'h7fff, 8'($urandom));
		drive_word(g711c_pkg::FUNC_ENCODE, 16'h0000, 8'($urandom));
		drive_word(g711c_pkg::FUNC_ENCODE, 16'hffff, 8'($urandom));
		drive_word(g711c_pkg::FUNC_ENCODE, 16'h0008, 8'hff);
		drive_word(g711c_pkg::FUNC_DECODE, 16'($urandom), 8'h00);
		drive_word(g711c_pkg::FUNC_DECODE, 16'($urandom), 8'hff);
		drive_word(g711c_pkg::FUNC_DECODE, 16'hffff, 8'h80);
		drive_word(g711c_pkg::FUNC_DECODE, 16'($urandom), 8'h7f);
		drive_word(g711c_pkg::FUNC_DECODE, 16'($urandom), 8'h55);
	endtask

	// Random words. Samples are spread over the whole range, bunched near zero where the
	// smallest segments live, and pushed against both ends of the range.
	task automatic run_random(input int count);
		logic        func;
		logic [15:0] pcm;
		logic [7:0]  code;
		for (int n = 0; n < count; n++) begin
			if (n % 32 == 0) begin
				src_idle_pct  = pick_idle_pct();
				sink_idle_pct = pick_idle_pct();
			end
			func = 1'($urandom_range(0, 1));
			code = 8'($urandom);
			case ($urandom_range(0, 3))
				0, 1: pcm = 16'($urandom);
				2: pcm = 16'($urandom_range(0, 511)) - 16'd256;
				default: begin
					if ($urandom_range(0, 1) == 1) begin
						pcm = 16'h8000 + 16'($urandom_range(0, 7));
					end else begin
						pcm = 16'h7fff - 16'($urandom_range(0, 7));
					end
				end
			endcase
			drive_word(func, pcm, code);
		end
	endtask

	// Output side: checks every word taken, then decides whether to take the next one.
	// Stalls come in bursts; during the closing part tready stays high.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				sb.check_result(m_axis_tdata);
			end
			if (quiet) begin
				m_axis_tready <= 1'b1;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 99) < sink_idle_pct) begin
				m_axis_tready <= 1'b0;
				stall_left = $urandom_range(1, 13) - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run when no word moves on any channel for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("status: fail");
		$finish;
	end

	// Main sequence. The first phase runs on the law left by reset, with no register write,
	// so the reset value is checked too. Every later law change happens with the block empty.
	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		set_law(g711c_pkg::LAW_A);
		run_directed();

		run_random(140);
		set_law(g711c_pkg::LAW_MU);
		run_random(140);
		set_law(g711c_pkg::LAW_A);
		run_random(140);
		set_law(g711c_pkg::LAW_MU);
		quiet = 1'b1;
		run_random(130);

		s_axis_tvalid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
